FILE: hdl/plb_pkg.sv
// shared constants and types for the positional list buffer
package plb_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int POS_W     = 5;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;
  // wide enough for any position or count up to the largest depth
  localparam int CMP_W     = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_DUMP_RD,
    S_DUMP_WAIT,
    S_RESP
  } state_t;

endpackage

FILE: hdl/plb_ram.sv
// single write port, single read port entry store with registered read data
module plb_ram #(
  parameter int DEPTH = plb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [plb_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [plb_pkg::DATA_W-1:0] rdata
);
  import plb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/positional_list_buffer_core.sv
// positional list buffer: ordered list in a store with registered read data, insert/delete/dump
// each transfer: an accept state, the command phase, then the result load, which waits on the output
// insert: shift from the old tail down to the position, then write the value; errors and unused commands: result only
// delete: copy each entry after the position into the slot before it, up to the tail
// dump: each stored entry is read through the single read port and loaded from its registered data
// one transfer in flight; synchronous active-high reset empties the list and drops any result
module positional_list_buffer_core #(
  parameter int DEPTH = plb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [plb_pkg::CMD_W-1:0]    command,
  input  logic [plb_pkg::POS_W-1:0]    position,
  input  logic signed [plb_pkg::DATA_W-1:0] data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [plb_pkg::ST_W-1:0]     status,
  output logic signed [plb_pkg::DATA_W-1:0] data_out,
  output logic [plb_pkg::CNT_OUT_W-1:0] entry_count,
  output logic                         last
);
  import plb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  // list bookkeeping
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;        // walking index of the shift or dump
  logic [AW-1:0]     pos_q;      // target slot of the current command
  logic [DATA_W-1:0] val_q;      // value being inserted
  status_t           st_q;       // status of a single-result command
  logic              pend;       // a read was issued last cycle and awaits write-back
  logic [AW-1:0]     pend_addr;  // destination of that pending write-back

  // store port
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // control
  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic              load_dump;
  logic              ins_more, del_more, dump_last;
  logic [CMP_W-1:0]  pos_w, cnt_w;
  status_t           chk_st;

  plb_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // insert shifts downward from the old tail, delete pulls upward toward the tail
  assign ins_more  = idx > pos_q;
  assign del_more  = CW'(idx) < count;
  assign dump_last = (CW'(idx) + CW'(1)) == count;

  assign pos_w = CMP_W'(position);
  assign cnt_w = CMP_W'(count);

  // validity check of the incoming command against the current list
  always_comb begin
    chk_st = ST_OK;
    case (command)
      CMD_INSERT: begin
        if (count == CW'(DEPTH)) begin
          chk_st = ST_FULL;
        end else if (pos_w > cnt_w) begin
          chk_st = ST_BAD_POS;
        end
      end
      CMD_DELETE: begin
        if (count == '0) begin
          chk_st = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          chk_st = ST_BAD_POS;
        end
      end
      CMD_DUMP: begin
        if (count == '0) begin
          chk_st = ST_EMPTY;
        end
      end
      default: chk_st = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (chk_st != ST_OK) begin
            state_next = S_RESP;
          end else if (command == CMD_INSERT) begin
            state_next = S_INS;
          end else if (command == CMD_DELETE) begin
            state_next = S_DEL;
          end else if (command == CMD_DUMP) begin
            state_next = S_DUMP_RD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_INS: begin
        if (!ins_more && !pend) begin
          state_next = S_RESP;
        end
      end
      S_DEL: begin
        if (!del_more && !pend) begin
          state_next = S_RESP;
        end
      end
      S_DUMP_RD: state_next = S_DUMP_WAIT;
      S_DUMP_WAIT: begin
        if (out_free) begin
          state_next = dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the controller: handshake, store port and result load
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx;
    out_load  = 1'b0;
    load_dump = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_INS: begin
        if (ins_more) begin
          mem_re    = 1'b1;
          mem_raddr = idx - AW'(1);
        end
        if (pend) begin
          mem_we = 1'b1;
        end else if (!ins_more) begin
          // shift done, drop the new value into its slot
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = val_q;
        end
      end
      S_DEL: begin
        if (del_more) begin
          mem_re    = 1'b1;
          mem_raddr = idx + AW'(1);
        end
        mem_we = pend;
      end
      S_DUMP_RD: mem_re = 1'b1;
      S_DUMP_WAIT: begin
        out_load  = out_free;
        load_dump = 1'b1;
      end
      S_RESP: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (in_xfer && chk_st == ST_OK) begin
            // the count moves at acceptance, the result reports the new value
            if (command == CMD_INSERT) begin
              count <= count + CW'(1);
            end else if (command == CMD_DELETE) begin
              count <= count - CW'(1);
            end
          end
        end
        S_INS: pend <= ins_more;
        S_DEL: pend <= del_more;
        default: pend <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          st_q  <= chk_st;
          pos_q <= AW'(position);
          val_q <= data_in;
          if (command == CMD_INSERT) begin
            idx <= AW'(count);
          end else if (command == CMD_DELETE) begin
            idx <= AW'(position);
          end else begin
            idx <= '0;
          end
        end
      end
      S_INS: begin
        pend_addr <= idx;
        if (ins_more) begin
          idx <= idx - AW'(1);
        end
      end
      S_DEL: begin
        pend_addr <= idx;
        if (del_more) begin
          idx <= idx + AW'(1);
        end
      end
      S_DUMP_WAIT: begin
        if (out_free && !dump_last) begin
          idx <= idx + AW'(1);
        end
      end
      default: pend_addr <= pend_addr;
    endcase
  end

  // result register, frees the controller from the output side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      entry_count <= CNT_OUT_W'(count);
      if (load_dump) begin
        status   <= ST_OK;
        data_out <= mem_rdata;
        last     <= dump_last;
      end else begin
        status   <= st_q;
        data_out <= '0;
        last     <= 1'b1;
      end
    end
  end

endmodule

FILE: sim/positional_list_buffer_core_tb.sv
// testbench for the positional list buffer: random traffic checked against a list predictor
module positional_list_buffer_core_tb;
  import plb_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_START = 1200;
  localparam int HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_TARGET = 362;
  localparam int REPORT_MAX = 60;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       gap;    // idle cycles after this transfer
    bit                       drain;  // hold until every result is back
  } list_cmd_t;

  typedef struct {
    status_t                  st;
    logic signed [DATA_W-1:0] data;
    logic [CNT_OUT_W-1:0]     cnt;
    logic                     last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] command = CMD_DUMP;
  logic [POS_W-1:0] position = '0;
  logic signed [DATA_W-1:0] data_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] status;
  logic signed [DATA_W-1:0] data_out;
  logic [CNT_OUT_W-1:0] entry_count;
  logic last;

  list_cmd_t pending_cmds[$];
  list_cmd_t cur_cmd;
  list_result_t expected_results[$];
  logic signed [DATA_W-1:0] shadow_list[$];

  int errors = 0;
  int gen_cnt = 0;
  bit tx_quiet = 1'b0;
  int tx_idle = 0;
  int rx_wait = 0;
  bit rx_quiet = 1'b0;
  int results_seen = 0;
  int cyc = 0;
  logic rx_hold = 1'b0;
  bit results_settled = 1'b1;

  positional_list_buffer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .position(position),
    .data_in(data_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .data_out(data_out),
    .entry_count(entry_count),
    .last(last)
  );

  always #5 clk = ~clk;

  // list predictor: applies one accepted command and queues the results it causes
  function automatic void predict_list_op(input list_cmd_t c);
    list_result_t r;
    int n;
    r.st = ST_OK;
    r.data = '0;
    r.last = 1'b1;
    n = shadow_list.size();
    case (c.cmd)
      CMD_INSERT: begin
        if (n >= LIST_DEPTH) r.st = ST_FULL;
        else if (int'(c.pos) > n) r.st = ST_BAD_POS;
        else shadow_list.insert(int'(c.pos), c.val);
      end
      CMD_DELETE: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (int'(c.pos) >= n) r.st = ST_BAD_POS;
        else shadow_list.delete(int'(c.pos));
      end
      CMD_DUMP: begin
        if (n == 0) begin
          r.st = ST_EMPTY;
        end else begin
          // one result per stored value, last on the final one
          for (int i = 0; i < n; i++) begin
            r.data = shadow_list[i];
            r.cnt = n[CNT_OUT_W-1:0];
            r.last = (i == n - 1);
            expected_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.cnt = CNT_OUT_W'(shadow_list.size());
    expected_results.push_back(r);
  endfunction

  function automatic void check_result();
    list_result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t: expected none, actual status=%0d data_out=%0d count=%0d last=%0b",
                 $time, status, data_out, entry_count, last);
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.st || data_out !== want.data || entry_count !== want.cnt ||
        last !== want.last) begin
      errors++;
      if (errors <= REPORT_MAX) begin
        if (status !== want.st)
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        if (data_out !== want.data)
          $display("%0t: data_out expected %0d actual %0d", $time, want.data, data_out);
        if (entry_count !== want.cnt)
          $display("%0t: entry_count expected %0d actual %0d", $time, want.cnt, entry_count);
        if (last !== want.last)
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
      end
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // queue one command and keep a rough count of the list for shaping later commands
  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                         input logic signed [DATA_W-1:0] val, input bit drain);
    list_cmd_t c;
    c.cmd = cmd;
    c.pos = pos[POS_W-1:0];
    c.val = val;
    c.gap = tx_quiet ? 0 : $urandom_range(0, 12);
    c.drain = drain;
    if (cmd == CMD_INSERT && gen_cnt < LIST_DEPTH && pos <= gen_cnt) gen_cnt++;
    else if (cmd == CMD_DELETE && pos < gen_cnt) gen_cnt--;
    pending_cmds.push_back(c);
  endtask

  // sender: presents queued commands, holds each until its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_idle = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_list_op(cur_cmd);
        tx_idle = cur_cmd.gap;
      end
      if (!in_valid || in_ready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     (!pending_cmds[0].drain ||
                      (results_settled && !(in_valid && in_ready)))) begin
          cur_cmd = pending_cmds.pop_front();
          command <= cur_cmd.cmd;
          position <= cur_cmd.pos;
          data_in <= cur_cmd.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sampled away from the active edge so the sender sees a stable view
  always @(negedge clk) results_settled <= (expected_results.size() == 0);

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      cyc <= 0;
      rx_hold <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      rx_hold <= (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN);
    end
  end

  // receiver: checks each result transfer, then stalls a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        results_seen++;
        if (results_seen % 48 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 12);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= !rx_hold && rx_wait == 0;
    end
  end

  initial begin
    int ep;
    int kind;
    int r;

    // directed: empty list errors, extremes, every command and edge position
    add_cmd(CMD_DUMP, 0, 0, 1'b0);
    add_cmd(CMD_DELETE, 0, 0, 1'b0);
    add_cmd(CMD_INSERT, 1, 32'sh1234_5678, 1'b0);
    add_cmd(CMD_INSERT, 0, 32'sh8000_0000, 1'b0);
    add_cmd(CMD_INSERT, 1, 32'sh7fff_ffff, 1'b0);
    add_cmd(CMD_INSERT, 0, -32'sd1, 1'b0);
    add_cmd(CMD_INSERT, 31, 0, 1'b0);
    add_cmd(CMD_INSERT, 2, 32'sh5a5a_5a5a, 1'b0);
    add_cmd(CMD_DELETE, 4, 0, 1'b0);
    add_cmd(CMD_DELETE, 31, -32'sd1, 1'b0);
    add_cmd(CMD_UNUSED, 31, 32'sh7fff_ffff, 1'b0);
    add_cmd(CMD_DUMP, 31, -32'sd1, 1'b0);
    add_cmd(CMD_DELETE, 1, 0, 1'b0);
    add_cmd(CMD_DELETE, 2, 0, 1'b0);
    add_cmd(CMD_DELETE, 0, 0, 1'b0);
    // deleting the only entry empties the list
    add_cmd(CMD_DELETE, 0, 0, 1'b0);
    add_cmd(CMD_DUMP, 0, 0, 1'b0);
    add_cmd(CMD_UNUSED, 0, 0, 1'b0);

    // random episodes: fill to full, drain to empty, or mixed traffic
    ep = 0;
    while (pending_cmds.size() < RANDOM_TARGET) begin
      kind = (ep == 0) ? 0 : (ep == 1) ? 2 : $urandom_range(0, 9);
      tx_quiet = ($urandom_range(0, 3) == 0);
      if (ep == 2 || $urandom_range(0, 4) == 0)
        add_cmd(CMD_DUMP, $urandom_range(0, 31), rand_word(), 1'b1);
      if (kind < 2) begin
        while (gen_cnt < LIST_DEPTH)
          add_cmd(CMD_INSERT, $urandom_range(0, gen_cnt), rand_word(), 1'b0);
        add_cmd(CMD_INSERT, $urandom_range(0, 31), rand_word(), 1'b0);
        add_cmd(CMD_DELETE, LIST_DEPTH, 0, 1'b0);
        add_cmd(CMD_DUMP, 0, 0, 1'b0);
        add_cmd(CMD_DELETE, LIST_DEPTH - 1, 0, 1'b0);
      end else if (kind < 4) begin
        while (gen_cnt > 0)
          add_cmd(CMD_DELETE, $urandom_range(0, gen_cnt - 1), rand_word(), 1'b0);
        add_cmd(CMD_DELETE, $urandom_range(0, 31), 0, 1'b0);
        add_cmd(CMD_DUMP, 0, 0, 1'b0);
      end else begin
        repeat (10) begin
          r = $urandom_range(0, 99);
          if (r < 40)
            add_cmd(CMD_INSERT, $urandom_range(0, gen_cnt), rand_word(), 1'b0);
          else if (r < 68)
            add_cmd(CMD_DELETE, (gen_cnt == 0) ? 0 : $urandom_range(0, gen_cnt - 1),
                    rand_word(), 1'b0);
          else if (r < 80)
            add_cmd(CMD_DUMP, $urandom_range(0, 31), rand_word(), 1'b0);
          else if (r < 93)
            add_cmd(r[0] ? CMD_INSERT : CMD_DELETE, $urandom_range(0, 31), rand_word(), 1'b0);
          else
            add_cmd(CMD_UNUSED, $urandom_range(0, 31), rand_word(), 1'b0);
        end
      end
      ep++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // checked between edges so the sender's updates of this edge are already visible
    while (pending_cmds.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    // a late extra result would still show up in the receiver
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
